/* sv/attribute_list_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// Attribute list tokenizer assertion macros
// Shared property forms for the checker of the tokenizer ports.
// ----------------------------------------------------------------------------
`ifndef ATTRIBUTE_LIST_TOKENIZER_DEFINES_SVH
`define ATTRIBUTE_LIST_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ALT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/alt_pkg.sv */
// ----------------------------------------------------------------------------
// Attribute list tokenizer package
// Request and result types, character constants and result kinds.
// ----------------------------------------------------------------------------
package alt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic KIND_NAMED      = 1'b0;
    localparam logic KIND_POSITIONAL = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       no_char;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] key_offset;
        logic [12:0] key_length;
        logic [11:0] position;
        logic [12:0] value_offset;
        logic [12:0] value_length;
        logic        at_end;
        logic        overflow;
    } rsp_t;

endpackage

/* sv/attribute_list_tokenizer.sv */
// ----------------------------------------------------------------------------
// Attribute list tokenizer
// Splits attribute list content into named pairs and positional values.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries one character per
//   request, with last marking the end of the content and no_char marking a
//   request without a character (used to end empty content).
//   The result channel (rsp_valid, rsp_stall, rsp) carries at most one token
//   result per request: kind, key and value spans as offsets from the start
//   of the content, positional number, at_end and overflow.
//   A request sits in the input register while the token logic feeds the
//   result register.
//   Throughput is one request per cycle while rsp_stall holds no result, set
//   by the single token state update between the input and result registers.
//   While a result is held under rsp_stall, req_stall rises once the input
//   register is full; nothing is lost or repeated.
//   Reset clears all token state; the next request starts a fresh content.
//   Characters beyond MAX_CONTENT are ignored and flag overflow.
// ----------------------------------------------------------------------------
module attribute_list_tokenizer
#(
    parameter int MAX_CONTENT = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  alt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output alt_pkg::rsp_t rsp
);
    import alt_pkg::*;

    logic take;
    logic item_valid;
    req_t item;

    alt_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    alt_core
    #(
        .MAX_CONTENT (MAX_CONTENT)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

/* sv/alt_in_stage.sv */
// ----------------------------------------------------------------------------
// Attribute list tokenizer input stage
// Registers one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module alt_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  alt_pkg::req_t req,
    input  logic          take,
    output logic          item_valid,
    output alt_pkg::req_t item
);
    import alt_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    req_t item_next;

    assign req_stall = valid_reg && !take;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (!req_stall)
        begin
            valid_next = req_valid;
            item_next  = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/alt_core.sv */
// ----------------------------------------------------------------------------
// Attribute list tokenizer core
// Per-character token state, span calculation and the result register.
// ----------------------------------------------------------------------------
module alt_core
#(
    parameter int MAX_CONTENT = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  alt_pkg::req_t item,
    output logic          take,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output alt_pkg::rsp_t rsp
);
    import alt_pkg::*;

    localparam int CW = $clog2(MAX_CONTENT + 1);

    logic [CW-1:0] char_count_reg,        char_count_next;
    logic          in_token_reg,          in_token_next;
    logic          quote_open_reg,        quote_open_next;
    logic [CW-1:0] token_start_reg,       token_start_next;
    logic          equals_seen_reg,       equals_seen_next;
    logic [CW-1:0] key_end_reg,           key_end_next;
    logic          value_started_reg,     value_started_next;
    logic [CW-1:0] value_first_pos_reg,   value_first_pos_next;
    logic          value_starts_quote_reg, value_starts_quote_next;
    logic [CW-1:0] last_nonblank_end_reg, last_nonblank_end_next;
    logic          last_nonblank_quote_reg, last_nonblank_quote_next;
    logic [11:0]   next_position_reg,     next_position_next;
    logic          too_long_reg,          too_long_next;
    logic          rsp_valid_reg,         rsp_valid_next;
    rsp_t          rsp_reg,               rsp_next;

    logic          out_free;
    logic          fire;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign take     = out_free;
    assign fire     = item_valid && out_free;

    always_comb
    begin
        logic          has_char;
        logic          fits;
        logic          accept_ch;
        logic          blank;
        logic          is_comma;
        logic          is_quote;
        logic          close;
        logic          finish;
        logic          strip;
        logic          keep;
        logic          sq;
        logic [CW-1:0] p;
        logic [CW-1:0] klen;
        logic [CW-1:0] voff;
        logic [CW-1:0] vlen;

        char_count_next          = char_count_reg;
        in_token_next            = in_token_reg;
        quote_open_next          = quote_open_reg;
        token_start_next         = token_start_reg;
        equals_seen_next         = equals_seen_reg;
        key_end_next             = key_end_reg;
        value_started_next       = value_started_reg;
        value_first_pos_next     = value_first_pos_reg;
        value_starts_quote_next  = value_starts_quote_reg;
        last_nonblank_end_next   = last_nonblank_end_reg;
        last_nonblank_quote_next = last_nonblank_quote_reg;
        next_position_next       = next_position_reg;
        rsp_next                 = rsp_reg;
        rsp_valid_next           = rsp_valid_reg && rsp_stall;

        has_char  = !item.no_char;
        fits      = char_count_reg < CW'(MAX_CONTENT);
        accept_ch = fire && has_char && fits;
        too_long_next = too_long_reg || (fire && has_char && !fits);
        p         = char_count_reg;
        blank     = (item.ch == CH_SPACE) || (item.ch == CH_TAB);
        is_comma  = item.ch == CH_COMMA;
        is_quote  = item.ch == CH_QUOTE;
        close     = 1'b0;

        if (accept_ch)
        begin
            char_count_next = p + CW'(1);
            if (!in_token_reg && !is_comma && !blank)
            begin
                in_token_next            = 1'b1;
                quote_open_next          = 1'b0;
                token_start_next         = p;
                equals_seen_next         = 1'b0;
                key_end_next             = p;
                value_started_next       = 1'b0;
                value_first_pos_next     = p;
                value_starts_quote_next  = is_quote;
                last_nonblank_end_next   = p;
                last_nonblank_quote_next = 1'b0;
            end
            if (in_token_next)
            begin
                if (is_comma && !quote_open_next)
                begin
                    close = 1'b1;
                end
                else
                begin
                    if (is_quote)
                    begin
                        quote_open_next = !quote_open_next;
                    end
                    if (item.ch == CH_EQUAL && !quote_open_next && !equals_seen_next)
                    begin
                        key_end_next            = last_nonblank_end_next;
                        equals_seen_next        = 1'b1;
                        value_started_next      = 1'b0;
                        value_first_pos_next    = p + CW'(1);
                        value_starts_quote_next = 1'b0;
                    end
                    else if (equals_seen_next && !value_started_next && !blank)
                    begin
                        value_started_next      = 1'b1;
                        value_first_pos_next    = p;
                        value_starts_quote_next = is_quote;
                    end
                    if (!blank)
                    begin
                        last_nonblank_end_next   = p + CW'(1);
                        last_nonblank_quote_next = is_quote;
                    end
                end
            end
        end

        finish = in_token_next && (close || (fire && item.last));

        klen = key_end_next - token_start_next;
        if (equals_seen_next)
        begin
            voff = value_first_pos_next;
            vlen = last_nonblank_end_next - value_first_pos_next;
            sq   = value_started_next && value_starts_quote_next;
        end
        else
        begin
            voff = token_start_next;
            vlen = last_nonblank_end_next - token_start_next;
            sq   = value_starts_quote_next;
        end
        strip = (vlen >= CW'(2)) && sq && last_nonblank_quote_next;
        if (strip)
        begin
            voff = voff + CW'(1);
            vlen = vlen - CW'(2);
        end
        keep = equals_seen_next ? (klen != '0) : (vlen != '0);

        if (finish)
        begin
            in_token_next   = 1'b0;
            quote_open_next = 1'b0;
            if (keep)
            begin
                rsp_valid_next        = 1'b1;
                rsp_next.kind         = equals_seen_next ? KIND_NAMED : KIND_POSITIONAL;
                rsp_next.key_offset   = equals_seen_next ? 12'(token_start_next) : 12'd0;
                rsp_next.key_length   = equals_seen_next ? 13'(klen) : 13'd0;
                rsp_next.position     = equals_seen_next ? 12'd0 : next_position_reg;
                rsp_next.value_offset = 13'(voff);
                rsp_next.value_length = 13'(vlen);
                rsp_next.at_end       = item.last;
                rsp_next.overflow     = too_long_next;
                if (!equals_seen_next)
                begin
                    next_position_next = next_position_reg + 12'd1;
                end
            end
        end

        if (fire && item.last)
        begin
            char_count_next          = '0;
            in_token_next            = 1'b0;
            quote_open_next          = 1'b0;
            token_start_next         = '0;
            equals_seen_next         = 1'b0;
            key_end_next             = '0;
            value_started_next       = 1'b0;
            value_first_pos_next     = '0;
            value_starts_quote_next  = 1'b0;
            last_nonblank_end_next   = '0;
            last_nonblank_quote_next = 1'b0;
            next_position_next       = 12'd1;
            too_long_next            = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg          <= '0;
            in_token_reg            <= 1'b0;
            quote_open_reg          <= 1'b0;
            token_start_reg         <= '0;
            equals_seen_reg         <= 1'b0;
            key_end_reg             <= '0;
            value_started_reg       <= 1'b0;
            value_first_pos_reg     <= '0;
            value_starts_quote_reg  <= 1'b0;
            last_nonblank_end_reg   <= '0;
            last_nonblank_quote_reg <= 1'b0;
            next_position_reg       <= 12'd1;
            too_long_reg            <= 1'b0;
            rsp_valid_reg           <= 1'b0;
        end
        else
        begin
            char_count_reg          <= char_count_next;
            in_token_reg            <= in_token_next;
            quote_open_reg          <= quote_open_next;
            token_start_reg         <= token_start_next;
            equals_seen_reg         <= equals_seen_next;
            key_end_reg             <= key_end_next;
            value_started_reg       <= value_started_next;
            value_first_pos_reg     <= value_first_pos_next;
            value_starts_quote_reg  <= value_starts_quote_next;
            last_nonblank_end_reg   <= last_nonblank_end_next;
            last_nonblank_quote_reg <= last_nonblank_quote_next;
            next_position_reg       <= next_position_next;
            too_long_reg            <= too_long_next;
            rsp_valid_reg           <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sv/alt_checker.sv */
// ----------------------------------------------------------------------------
// Attribute list tokenizer checker
// Port-level properties of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "attribute_list_tokenizer_defines.svh"

module alt_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input alt_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input alt_pkg::rsp_t rsp
);
    import alt_pkg::*;

    `ALT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
    `ALT_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !rsp_valid, !req_stall, "request stalled with empty output")
    `ALT_ASSERT_NOW(a_named_no_position, clk, rst_n, rsp_valid && rsp.kind == KIND_NAMED, rsp.position == 12'd0, "named pair carries a position")
    `ALT_ASSERT_NOW(a_positional_no_key, clk, rst_n, rsp_valid && rsp.kind == KIND_POSITIONAL, rsp.key_offset == 12'd0 && rsp.key_length == 13'd0 && rsp.value_length != 13'd0, "bad positional result")

endmodule

bind attribute_list_tokenizer alt_checker u_alt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
